>>> rtl/pdc_pkg.sv
// shared types, letter codes and helper functions for the playfair digraph cipher
// no dependencies; imported by pdc_locate and playfair_digraph_cipher
package pdc_pkg;

    typedef logic [4:0]  letter_t;
    typedef logic [24:0] row_t;
    typedef row_t [4:0]  square_t;
    typedef logic [2:0]  coord_t;

    // position of a letter in the key square
    typedef struct packed {
        logic   found;
        coord_t row;
        coord_t col;
    } loc_t;

    localparam int      SQUARE_DIM = 5;
    localparam int      ROW_WIDTH  = 25;
    localparam int      CFG_IDX_W  = 3;

    localparam letter_t LETTER_I = 5'd8;
    localparam letter_t LETTER_J = 5'd9;
    localparam letter_t LETTER_X = 5'd23;
    localparam letter_t LETTER_Y = 5'd24;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_4 = 3'd4;

    // alphabet without j, row-major
    localparam row_t ROW_0_RESET = 25'd4294688;
    localparam row_t ROW_1_RESET = 25'd10755269;
    localparam row_t ROW_2_RESET = 25'd16201099;
    localparam row_t ROW_3_RESET = 25'd21613104;
    localparam row_t ROW_4_RESET = 25'd27025109;

    // one step around the square, forward or backward, modulo 5
    function automatic coord_t step5(input coord_t v, input logic op);
        coord_t r;
        if (op == OP_DECRYPT)
        begin
            r = (v == 3'd0) ? 3'd4 : v - 3'd1;
        end
        else
        begin
            r = (v == 3'd4) ? 3'd0 : v + 3'd1;
        end
        return r;
    endfunction

    function automatic letter_t cell_at(input square_t sq, input coord_t r, input coord_t c);
        letter_t v;
        v = sq[r][c*5 +: 5];
        return v;
    endfunction

endpackage

>>> rtl/pdc_locate.sv
// finds the first row-major cell of the key square that holds a letter
// depends on pdc_pkg
module pdc_locate (
    input  pdc_pkg::square_t square,
    input  pdc_pkg::letter_t letter,
    output pdc_pkg::loc_t    loc
);
    import pdc_pkg::*;

    // scan from the last cell back so the earliest match wins
    always_comb
    begin
        loc = '0;
        for (int r = SQUARE_DIM - 1; r >= 0; r--)
        begin
            for (int c = SQUARE_DIM - 1; c >= 0; c--)
            begin
                if (square[r][c*5 +: 5] == letter)
                begin
                    loc.found = 1'b1;
                    loc.row   = 3'(r);
                    loc.col   = 3'(c);
                end
            end
        end
    end

endmodule

>>> rtl/playfair_digraph_cipher.sv
// top level of the playfair digraph cipher: config registers, input and result stages
// depends on pdc_pkg and pdc_locate
//
// Usage:
//   Software loads the 5x5 key square through cfg_we / cfg_index / cfg_data,
//   one 25-bit row per index 0..4 (column 0 in the low five bits). Writes take
//   effect at once and should be made while no pair is in flight.
//   Input channel (in_valid / in_ready) carries one letter pair, the operation
//   (0 encrypt, 1 decrypt) and has_second. Output channel (out_valid /
//   out_ready) returns the two result letters and not_found.
//   A transferred pair is held in the input register; its result is then
//   registered in the result register, where out_valid rises.
//   Throughput: one pair per cycle while the receiver does not stall; the
//   lookup, rule selection and cell fetch are a single combinational pass
//   between the two register stages.
//   When the receiver stalls, the result is held and the input register
//   still fills, so one more pair is taken before in_ready drops.
//   Reset loads the square with the alphabet without j and empties both
//   stages.
module playfair_digraph_cipher (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [24:0]                cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       operation,
    input  pdc_pkg::letter_t           first_letter,
    input  pdc_pkg::letter_t           second_letter,
    input  logic                       has_second,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pdc_pkg::letter_t           first_out,
    output pdc_pkg::letter_t           second_out,
    output logic                       not_found
);
    import pdc_pkg::*;

    square_t square_reg;

    logic    s1_valid_reg;
    logic    op_reg;
    letter_t a_reg;
    letter_t b_reg;
    logic    has_reg;

    logic    out_valid_reg;
    letter_t first_out_reg;
    letter_t second_out_reg;
    logic    not_found_reg;

    logic    s1_advance;
    letter_t b_fill;
    letter_t b_pair;
    letter_t a_prep;
    letter_t b_prep;
    loc_t    loc_a;
    loc_t    loc_b;
    letter_t first_next;
    letter_t second_next;
    logic    not_found_next;

    // key square rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg[0] <= ROW_0_RESET;
            square_reg[1] <= ROW_1_RESET;
            square_reg[2] <= ROW_2_RESET;
            square_reg[3] <= ROW_3_RESET;
            square_reg[4] <= ROW_4_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_0: square_reg[0] <= cfg_data;
                REG_ROW_1: square_reg[1] <= cfg_data;
                REG_ROW_2: square_reg[2] <= cfg_data;
                REG_ROW_3: square_reg[3] <= cfg_data;
                REG_ROW_4: square_reg[4] <= cfg_data;
                default:   ;
            endcase
        end
    end

    // input stage moves on when the result register is free or being drained
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg  <= operation;
            a_reg   <= first_letter;
            b_reg   <= second_letter;
            has_reg <= has_second;
        end
    end

    // pair preparation: odd tail, doubled letters on raw codes, then j folds to i
    always_comb
    begin
        b_fill = has_reg ? b_reg : LETTER_X;
        if (a_reg == b_fill)
        begin
            b_pair = (a_reg == LETTER_X) ? LETTER_Y : LETTER_X;
        end
        else
        begin
            b_pair = b_fill;
        end
        a_prep = (a_reg == LETTER_J) ? LETTER_I : a_reg;
        b_prep = (b_pair == LETTER_J) ? LETTER_I : b_pair;
    end

    pdc_locate u_locate_a (
        .square (square_reg),
        .letter (a_prep),
        .loc    (loc_a)
    );

    pdc_locate u_locate_b (
        .square (square_reg),
        .letter (b_prep),
        .loc    (loc_b)
    );

    always_comb
    begin
        not_found_next = !(loc_a.found && loc_b.found);
        if (not_found_next)
        begin
            first_next  = '0;
            second_next = '0;
        end
        else if (loc_a.row == loc_b.row)
        begin
            first_next  = cell_at(square_reg, loc_a.row, step5(loc_a.col, op_reg));
            second_next = cell_at(square_reg, loc_b.row, step5(loc_b.col, op_reg));
        end
        else if (loc_a.col == loc_b.col)
        begin
            first_next  = cell_at(square_reg, step5(loc_a.row, op_reg), loc_a.col);
            second_next = cell_at(square_reg, step5(loc_b.row, op_reg), loc_b.col);
        end
        else
        begin
            // rectangle: swap columns
            first_next  = cell_at(square_reg, loc_a.row, loc_b.col);
            second_next = cell_at(square_reg, loc_b.row, loc_a.col);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            first_out_reg  <= first_next;
            second_out_reg <= second_next;
            not_found_reg  <= not_found_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign first_out  = first_out_reg;
    assign second_out = second_out_reg;
    assign not_found  = not_found_reg;

`ifndef SYNTHESIS
    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_found |-> first_out == '0 && second_out == '0)
        else $error("not_found result carries nonzero letters");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while result register empty");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("input stage did not move into empty result register");
`endif

endmodule
